// ----- rtl/mtpr_pkg.sv -----
// Package for the multi-timer bank with pause and resume.
// Holds request and mode codes, controller states and the command/status structs.
// No dependencies.
package mtpr_pkg;

    localparam int REQ_W  = 3;
    localparam int SEL_W  = 3;
    localparam int PVAL_W = 32;
    localparam int MODE_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK       = 3'd0,
        REQ_START      = 3'd1,
        REQ_PAUSE      = 3'd2,
        REQ_RESUME     = 3'd3,
        REQ_STOP       = 3'd4,
        REQ_REFRESH    = 3'd5,
        REQ_SET_PERIOD = 3'd6
    } req_e_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_INACTIVE = 2'd0,
        MODE_ACTIVE   = 2'd1,
        MODE_PAUSED   = 2'd2
    } mode_e_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_FLUSH
    } state_e_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;      // latch the incoming request
        logic tick;      // advance the time counter
        logic scan_clr;  // restart the scan index
        logic rd_en;     // read the timer memories at the current index
        logic exec;      // apply a single-timer request and load its result
        logic fire;      // apply an expiry at the scan index
        logic idx_inc;   // step the scan index
        logic flush;     // send the held expiry as the final result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_tick;
        logic out_free;
        logic hit;
        logic idx_last;
        logic pend_valid;
    } stat_t;

endpackage

// ----- rtl/mtpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mtpr_ctrl.sv -----
// Controller state machine for the multi-timer bank.
// Depends on mtpr_pkg for states and the command/status structs.
module mtpr_ctrl
    import mtpr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_e_t state_reg;
    state_e_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (stat.in_tick)
                    begin
                        cmd.tick     = 1'b1;
                        cmd.scan_clr = 1'b1;
                        state_next   = ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SCAN_EVAL;
            end
            ST_SCAN_EVAL:
            begin
                // A new expiry pushes the held one out first, so it waits for room.
                if (!(stat.hit && stat.pend_valid && !stat.out_free))
                begin
                    cmd.fire = stat.hit;
                    if (stat.idx_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_SCAN_RD;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/mtpr_dp.sv -----
// Datapath of the multi-timer bank: time counter, timer state, memories, output register.
// Depends on mtpr_pkg and mtpr_ram.
module mtpr_dp
    import mtpr_pkg::*;
#(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [SEL_W-1:0]  timer_sel,
    input  logic [PVAL_W-1:0] period_value,
    input  logic              one_shot_mark,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SEL_W-1:0]  timer_index,
    output logic              fired,
    output logic [MODE_W-1:0] timer_mode,
    output logic              last,
    input  cmd_t              cmd,
    output stat_t             stat
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Latched request.
    req_e_t            req_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [PVAL_W-1:0] pval_reg;
    logic              mark_reg;

    logic [TIME_WIDTH-1:0] now_reg;
    logic [IDX_W-1:0]      idx_reg;

    mode_e_t status_reg  [NUM_TIMERS];
    logic    one_shot_reg[NUM_TIMERS];
    logic    per_vld_reg [NUM_TIMERS];

    // Held expiry, sent once it is known whether another one follows.
    logic             pend_valid_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    mode_e_t          pend_mode_reg;

    logic              out_valid_reg;
    logic [SEL_W-1:0]  out_idx_reg;
    logic              out_fired_reg;
    logic [MODE_W-1:0] out_mode_reg;
    logic              out_last_reg;

    logic                  scan;
    logic                  sel_ok;
    logic [IDX_W-1:0]      sel_idx;
    logic [IDX_W-1:0]      acc_idx;
    mode_e_t               cur_mode;
    logic                  cur_one;
    logic [TIME_WIDTH-1:0] dl_q;
    logic [TIME_WIDTH-1:0] per_q;
    logic [TIME_WIDTH-1:0] per_cur;
    logic [TIME_WIDTH-1:0] dl_wdata;
    logic                  dl_we;
    logic                  per_we;
    logic [TIME_WIDTH-1:0] diff;
    logic                  hit;
    mode_e_t               exec_mode;
    logic                  exec_dl_we;
    logic [TIME_WIDTH-1:0] exec_dl;
    mode_e_t               fire_mode;
    logic                  out_free;

    assign scan     = (req_reg == REQ_TICK);
    assign sel_ok   = (32'(sel_reg) < NUM_TIMERS);
    assign sel_idx  = IDX_W'(sel_reg);
    assign acc_idx  = scan ? idx_reg : sel_idx;
    assign cur_mode = status_reg[acc_idx];
    assign cur_one  = one_shot_reg[acc_idx];
    assign per_cur  = per_vld_reg[acc_idx] ? per_q : TIME_WIDTH'(1);

    assign diff      = now_reg - dl_q;
    assign hit       = (cur_mode == MODE_ACTIVE) && !diff[TIME_WIDTH-1];
    assign fire_mode = cur_one ? MODE_INACTIVE : MODE_ACTIVE;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        exec_mode  = cur_mode;
        exec_dl_we = 1'b0;
        exec_dl    = now_reg + per_cur;
        case (req_reg)
            REQ_START:
            begin
                if (cur_mode == MODE_INACTIVE)
                begin
                    exec_mode  = MODE_ACTIVE;
                    exec_dl_we = 1'b1;
                end
            end
            REQ_PAUSE:
            begin
                if (cur_mode == MODE_ACTIVE)
                begin
                    exec_mode  = MODE_PAUSED;
                    exec_dl_we = 1'b1;
                    exec_dl    = dl_q - now_reg;
                end
            end
            REQ_RESUME:
            begin
                if (cur_mode == MODE_PAUSED)
                begin
                    exec_mode  = MODE_ACTIVE;
                    exec_dl_we = 1'b1;
                    exec_dl    = dl_q + now_reg;
                end
            end
            REQ_STOP:
            begin
                exec_mode = MODE_INACTIVE;
            end
            REQ_REFRESH:
            begin
                exec_mode  = MODE_ACTIVE;
                exec_dl_we = 1'b1;
            end
            default:
            begin
                exec_mode = cur_mode;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.fire)
        begin
            dl_we    = !cur_one;
            dl_wdata = dl_q + per_cur;
        end
        else
        begin
            dl_we    = cmd.exec && sel_ok && exec_dl_we;
            dl_wdata = exec_dl;
        end
    end

    assign per_we = cmd.exec && sel_ok && (req_reg == REQ_SET_PERIOD);

    mtpr_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (NUM_TIMERS),
        .AW    (IDX_W)
    ) u_deadline (
        .clk   (clk),
        .we    (dl_we),
        .waddr (acc_idx),
        .wdata (dl_wdata),
        .re    (cmd.rd_en),
        .raddr (acc_idx),
        .rdata (dl_q)
    );

    mtpr_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (NUM_TIMERS),
        .AW    (IDX_W)
    ) u_period (
        .clk   (clk),
        .we    (per_we),
        .waddr (acc_idx),
        .wdata (TIME_WIDTH'(pval_reg)),
        .re    (cmd.rd_en),
        .raddr (acc_idx),
        .rdata (per_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            req_reg  <= req_e_t'(req_type);
            sel_reg  <= timer_sel;
            pval_reg <= period_value;
            mark_reg <= one_shot_mark;
        end
        if (cmd.fire)
        begin
            pend_idx_reg  <= idx_reg;
            pend_mode_reg <= fire_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                status_reg[i]   <= MODE_INACTIVE;
                one_shot_reg[i] <= 1'b0;
                per_vld_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            if (cmd.tick)
            begin
                now_reg <= now_reg + TIME_WIDTH'(1);
            end
            if (cmd.scan_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.fire)
            begin
                pend_valid_reg       <= 1'b1;
                status_reg[idx_reg]  <= fire_mode;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.exec && sel_ok)
            begin
                status_reg[sel_idx] <= exec_mode;
                if (req_reg == REQ_SET_PERIOD)
                begin
                    one_shot_reg[sel_idx] <= mark_reg;
                    per_vld_reg[sel_idx]  <= 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec || cmd.flush || (cmd.fire && pend_valid_reg))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_idx_reg   <= sel_reg;
            out_fired_reg <= 1'b0;
            out_mode_reg  <= sel_ok ? exec_mode : MODE_INACTIVE;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.flush || (cmd.fire && pend_valid_reg))
        begin
            out_idx_reg   <= SEL_W'(pend_idx_reg);
            out_fired_reg <= 1'b1;
            out_mode_reg  <= pend_mode_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    assign out_valid   = out_valid_reg;
    assign timer_index = out_idx_reg;
    assign fired       = out_fired_reg;
    assign timer_mode  = out_mode_reg;
    assign last        = out_last_reg;

    assign stat.in_tick    = (req_type == REQ_TICK);
    assign stat.out_free   = out_free;
    assign stat.hit        = hit;
    assign stat.idx_last   = (idx_reg == IDX_W'(NUM_TIMERS - 1));
    assign stat.pend_valid = pend_valid_reg;

endmodule

// ----- rtl/multi_timer_pause_resume.sv -----
// Top level of the multi-timer bank with pause and resume.
// Depends on mtpr_pkg, mtpr_ctrl, mtpr_dp and mtpr_ram.
//
// A bank of NUM_TIMERS timers sharing one TIME_WIDTH-bit tick counter. Each
// request is one transfer on the input channel. A tick request advances the
// counter and then visits every timer in ascending index order, with one memory
// read of deadline and period and one evaluate and write back for each; the
// output side can stall the scan. Every expired active timer yields one
// result transfer with fired set; periodic timers reload their deadline by
// their period and one-shot timers go inactive. The final expiry of a tick has
// last set, and a tick with no expiry produces no result at all. Start, pause,
// resume, stop, refresh and set period each pass through accept, memory read
// and execute, and produce exactly one result with fired clear and last set,
// reporting the addressed timer's mode afterwards. Requests in the wrong state
// are ignored but still answered, and a timer_sel beyond the bank reports mode
// inactive. Deadlines and periods live in two small RAMs with a registered read
// port; that port and the per-timer scan set the tick duration. Results sit in
// an output register, so the next request is accepted while a finished result
// is still waiting to be taken.
module multi_timer_pause_resume
    import mtpr_pkg::*;
#(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [SEL_W-1:0]  timer_sel,
    input  logic [PVAL_W-1:0] period_value,
    input  logic              one_shot_mark,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SEL_W-1:0]  timer_index,
    output logic              fired,
    output logic [MODE_W-1:0] timer_mode,
    output logic              last
);

    // Commands and status between the state machine and the datapath.
    cmd_t  cmd;
    stat_t stat;

    // The controller sequences each request: accept, memory read, execute for
    // single-timer requests; read and evaluate per timer for a tick.
    mtpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the tick counter, the per-timer state, the deadline
    // and period memories, the held expiry and the output register.
    mtpr_dp #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_type      (req_type),
        .timer_sel     (timer_sel),
        .period_value  (period_value),
        .one_shot_mark (one_shot_mark),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .timer_index   (timer_index),
        .fired         (fired),
        .timer_mode    (timer_mode),
        .last          (last),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// ----- verif/tb_multi_timer_pause_resume.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the multi_timer_pause_resume timer bank.
// Depends on mtpr_pkg and the RTL of multi_timer_pause_resume; needs no other files.
module tb_multi_timer_pause_resume
    import mtpr_pkg::*;
;

    // The bank under test has eight timers with a 32-bit shared tick counter.
    localparam int NUM_TIMERS = 8;
    localparam int TIME_WIDTH = 32;

    // Request code 7 is not decoded by the block; it must be answered and change nothing.
    localparam logic [REQ_W-1:0] REQ_UNDECODED = 3'd7;

    // Run guard and the quiet time after the last report. A tick walks all
    // eight timers, with a read and an evaluation for each.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TICK_CYCLES  = 2 * NUM_TIMERS + 2;
    localparam int SETTLE_WAIT  = 2 * TICK_CYCLES + 4;
    localparam int IDLE_PERCENT = 27;

    // One report of the block as it appears on the output channel.
    typedef struct packed {
        logic [SEL_W-1:0]  idx;
        logic              fired;
        logic [MODE_W-1:0] mode;
        logic              last;
    } timer_report_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [REQ_W-1:0]  req_type;
    logic [SEL_W-1:0]  timer_sel;
    logic [PVAL_W-1:0] period_value;
    logic              one_shot_mark;
    logic              out_valid;
    logic              out_ready;
    logic [SEL_W-1:0]  timer_index;
    logic              fired;
    logic [MODE_W-1:0] timer_mode;
    logic              last;

    // Shadow copy of the timer bank, updated at every accepted request.
    logic [TIME_WIDTH-1:0] tick_now;
    logic [TIME_WIDTH-1:0] deadline_or_remaining [NUM_TIMERS];
    logic [TIME_WIDTH-1:0] reload_period [NUM_TIMERS];
    logic                  single_shot [NUM_TIMERS];
    mode_e_t               timer_state [NUM_TIMERS];

    // Reports that the shadow bank says are still owed by the block, oldest first.
    timer_report_t pending_reports [$];

    int  mismatch_count;
    int  cycle_count;
    bit  gaps_on;
    int  hold_request;

    multi_timer_pause_resume #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .timer_sel     (timer_sel),
        .period_value  (period_value),
        .one_shot_mark (one_shot_mark),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .timer_index   (timer_index),
        .fired         (fired),
        .timer_mode    (timer_mode),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advance the shadow bank by one accepted request and queue the reports it owes.
    // A tick owes one report per expired active timer in ascending order, and none
    // when nothing expires; every other request owes exactly one report.
    function automatic void predict_timer_bank(input logic [REQ_W-1:0] req,
                                               input logic [SEL_W-1:0] sel,
                                               input logic [PVAL_W-1:0] pval,
                                               input logic mark);
        timer_report_t         hits [NUM_TIMERS];
        timer_report_t         answer;
        logic [TIME_WIDTH-1:0] overdue;
        int                    hit_count;
        hit_count = 0;
        if (req == REQ_TICK)
        begin
            tick_now = tick_now + 1'b1;
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                overdue = tick_now - deadline_or_remaining[t];
                // The deadline counts as reached while the wrapped distance is below
                // half the counter range. Each timer is looked at once per tick, so a
                // reload that is still behind the counter waits for the next tick.
                if (timer_state[t] == MODE_ACTIVE && !overdue[TIME_WIDTH-1])
                begin
                    if (single_shot[t])
                        timer_state[t] = MODE_INACTIVE;
                    else
                        deadline_or_remaining[t] = deadline_or_remaining[t] + reload_period[t];
                    hits[hit_count] = '{idx: SEL_W'(t), fired: 1'b1,
                                        mode: timer_state[t], last: 1'b0};
                    hit_count++;
                end
            end
            for (int k = 0; k < hit_count; k++)
            begin
                answer = hits[k];
                answer.last = (k == hit_count - 1);
                pending_reports.push_back(answer);
            end
        end
        else
        begin
            // Requests in the wrong state leave the timer alone but are still answered.
            case (req)
                REQ_START:
                begin
                    if (timer_state[sel] == MODE_INACTIVE)
                    begin
                        deadline_or_remaining[sel] = tick_now + reload_period[sel];
                        timer_state[sel] = MODE_ACTIVE;
                    end
                end
                REQ_PAUSE:
                begin
                    if (timer_state[sel] == MODE_ACTIVE)
                    begin
                        deadline_or_remaining[sel] = deadline_or_remaining[sel] - tick_now;
                        timer_state[sel] = MODE_PAUSED;
                    end
                end
                REQ_RESUME:
                begin
                    if (timer_state[sel] == MODE_PAUSED)
                    begin
                        deadline_or_remaining[sel] = deadline_or_remaining[sel] + tick_now;
                        timer_state[sel] = MODE_ACTIVE;
                    end
                end
                REQ_STOP:
                    timer_state[sel] = MODE_INACTIVE;
                REQ_REFRESH:
                begin
                    // A stop followed by a start always rearms from the current count.
                    deadline_or_remaining[sel] = tick_now + reload_period[sel];
                    timer_state[sel] = MODE_ACTIVE;
                end
                REQ_SET_PERIOD:
                begin
                    // A running deadline stays where it is; the period is used at the
                    // next reload or start.
                    reload_period[sel] = pval[TIME_WIDTH-1:0];
                    single_shot[sel]   = mark;
                end
                default:
                    ;
            endcase
            answer = '{idx: sel, fired: 1'b0, mode: timer_state[sel], last: 1'b1};
            pending_reports.push_back(answer);
        end
    endfunction

    function automatic void check_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Output side: every transfer is compared field by field with the oldest owed report.
    always @(posedge clk)
    begin : report_check
        timer_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display({"%0t: unexpected report, expected none, ",
                          "actual index %0d fired %0d mode %0d last %0d"},
                         $time, timer_index, fired, timer_mode, last);
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("timer_index", 4'(want.idx), 4'(timer_index));
                check_field("fired", 4'(want.fired), 4'(fired));
                check_field("timer_mode", 4'(want.mode), 4'(timer_mode));
                check_field("last", 4'(want.last), 4'(last));
            end
        end
    end

    // Receiver: idles at random while gaps are on, and holds off for a whole stretch
    // of cycles whenever a test posts a hold request. The stretch is counted here.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(99) < IDLE_PERCENT)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached with %0d reports outstanding",
                     $time, pending_reports.size());
            $display("multi_timer_pause_resume regression: fail");
            $finish;
        end
    end

    // Offers one request and returns at the falling edge after its transfer. The
    // caller then either offers the next request or lowers in_valid at that edge,
    // so the same request is never taken twice.
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [SEL_W-1:0] sel,
                            input logic [PVAL_W-1:0] pval, input logic mark);
        while (gaps_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= req;
        timer_sel     <= sel;
        period_value  <= pval;
        one_shot_mark <= mark;
        do
            @(posedge clk);
        while (!in_ready);
        predict_timer_bank(req, sel, pval, mark);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_req(REQ_TICK, SEL_W'($urandom), $urandom, 1'($urandom));
    endtask

    // Sender pause: nothing is offered until every owed report has been seen.
    task automatic wait_reports_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Walks every request type and the corner cases on a few timers: wrong-state
    // requests, zero period, a period change under a running deadline, the widest
    // period, a one-shot expiry and the undecoded request code.
    task automatic test_directed_requests();
        send_req(REQ_SET_PERIOD, 3'd0, 32'd1, 1'b0);
        send_req(REQ_START, 3'd0, 32'd0, 1'b0);
        send_tick();
        send_req(REQ_PAUSE, 3'd0, 32'd0, 1'b0);
        send_req(REQ_PAUSE, 3'd0, 32'd0, 1'b0);
        send_tick();
        send_req(REQ_RESUME, 3'd0, 32'd0, 1'b0);
        send_req(REQ_RESUME, 3'd0, 32'd0, 1'b0);
        send_req(REQ_START, 3'd0, 32'd0, 1'b0);
        send_req(REQ_SET_PERIOD, 3'd0, 32'd3, 1'b0);
        send_req(REQ_STOP, 3'd0, 32'd0, 1'b0);
        send_req(REQ_STOP, 3'd0, 32'd0, 1'b0);
        send_req(REQ_REFRESH, 3'd0, 32'd0, 1'b0);
        send_req(REQ_SET_PERIOD, 3'd1, 32'd0, 1'b0);
        send_req(REQ_START, 3'd1, 32'd0, 1'b0);
        send_req(REQ_SET_PERIOD, 3'd2, 32'd2, 1'b1);
        send_req(REQ_START, 3'd2, 32'd0, 1'b0);
        send_req(REQ_SET_PERIOD, 3'd7, 32'hFFFF_FFFF, 1'b0);
        send_req(REQ_START, 3'd7, 32'd0, 1'b0);
        send_req(REQ_SET_PERIOD, 3'd4, 32'h8000_0000, 1'b0);
        send_req(REQ_REFRESH, 3'd4, 32'd0, 1'b0);
        send_req(REQ_UNDECODED, 3'd3, 32'hFFFF_FFFF, 1'b1);
        send_tick();
        send_tick();
        send_tick();
        wait_reports_drained();
    endtask

    // Every timer expires on the same ticks, so each tick owes the full eight reports.
    task automatic test_full_bank_tick();
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            send_req(REQ_SET_PERIOD, SEL_W'(t), 32'd1, 1'b0);
            send_req(REQ_REFRESH, SEL_W'(t), 32'd0, 1'b0);
        end
        send_tick();
        send_tick();
        send_req(REQ_SET_PERIOD, 3'd5, 32'd1, 1'b1);
        send_tick();
        wait_reports_drained();
    endtask

    // Builds one random request; periods are mostly short so that ticks keep firing.
    task automatic send_random_req();
        int               roll;
        logic [SEL_W-1:0] sel;
        logic [PVAL_W-1:0] pval;
        roll = $urandom_range(99);
        sel  = SEL_W'($urandom);
        case ($urandom_range(9))
            0:       pval = '0;
            1:       pval = $urandom;
            2:       pval = 32'h8000_0000 | $urandom;
            default: pval = PVAL_W'($urandom_range(6, 1));
        endcase
        if (roll < 40)
            send_tick();
        else if (roll < 52)
            send_req(REQ_START, sel, $urandom, 1'($urandom));
        else if (roll < 60)
            send_req(REQ_PAUSE, sel, $urandom, 1'($urandom));
        else if (roll < 68)
            send_req(REQ_RESUME, sel, $urandom, 1'($urandom));
        else if (roll < 74)
            send_req(REQ_STOP, sel, $urandom, 1'($urandom));
        else if (roll < 81)
            send_req(REQ_REFRESH, sel, $urandom, 1'($urandom));
        else if (roll < 97)
            send_req(REQ_SET_PERIOD, sel, pval, ($urandom_range(3) == 0));
        else
            send_req(REQ_UNDECODED, sel, $urandom, 1'($urandom));
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so the
    // output register fills and the block stops taking transfers on its input.
    task automatic test_output_backpressure();
        hold_request = 400;
        for (int t = 0; t < NUM_TIMERS; t++)
            send_req(REQ_REFRESH, SEL_W'(t), 32'd0, 1'b0);
        for (int n = 0; n < 30; n++)
            send_random_req();
        wait_reports_drained();
    endtask

    // Long random mix with a stretch where neither side idles, and a few points
    // where the sender waits for every owed report before going on.
    task automatic test_random_mix();
        for (int n = 0; n < 370; n++)
        begin
            gaps_on = !(n >= 150 && n < 250);
            send_random_req();
            if (n % 110 == 109)
                wait_reports_drained();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin : stimulus
        int settle;
        mismatch_count = 0;
        cycle_count    = 0;
        hold_request   = 0;
        gaps_on        = 1'b1;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        req_type       = REQ_TICK;
        timer_sel      = '0;
        period_value   = '0;
        one_shot_mark  = 1'b0;

        // Shadow bank in its reset state: counter zero, every timer inactive with
        // period one and periodic reload.
        tick_now = '0;
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            deadline_or_remaining[t] = '0;
            reload_period[t]         = 1;
            single_shot[t]           = 1'b0;
            timer_state[t]           = MODE_INACTIVE;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_requests();
        test_full_bank_tick();
        test_output_backpressure();
        test_random_mix();

        // All requests are in; wait for the owed reports, then stay a while longer
        // so that a stray extra report would still be caught.
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        for (settle = 0; settle < SETTLE_WAIT; settle++)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("multi_timer_pause_resume regression: pass");
        else
            $display("multi_timer_pause_resume regression: fail");
        $finish;
    end

endmodule
